FILE: sv/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// shared types, constants and the 5x8 font for the text console renderer
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int unsigned MaxColsDef    = 128;
  localparam int unsigned MaxRowsDef    = 64;
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CellColW = 7;
  localparam int unsigned CellRowW = 6;
  localparam int unsigned PixW   = 10;
  localparam int unsigned GlyphW = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRows    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOriginX = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgOriginY = 2'd3;

  localparam logic [7:0]  ColumnsRst = 8'd48;
  localparam logic [6:0]  RowsRst    = 7'd21;
  localparam logic [9:0]  OriginXRst = 10'd16;
  localparam logic [9:0]  OriginYRst = 10'd12;

  localparam logic [CharW-1:0] ChBs    = 8'h08;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0a;
  localparam logic [CharW-1:0] ChCr    = 8'h0d;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChGrave = 8'h60;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;
  localparam logic [CharW-1:0] ChBar   = 8'h7c;
  localparam logic [CharW-1:0] ChDel   = 8'h7f;
  localparam logic [CharW-1:0] CaseGap = 8'h20;

  localparam logic [5:0]        UnknownIdx  = 6'd31;
  localparam logic [GlyphW-1:0] GlyphSpace  = 40'h0000000000;
  localparam logic [GlyphW-1:0] GlyphBar    = 40'h0000ff0000;

  typedef enum logic [CmdW-1:0] {
    CMD_DRAW   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OP_DRAW = 3'd0,
    OP_TAB  = 3'd1,
    OP_BS   = 3'd2,
    OP_LF   = 3'd3,
    OP_CR   = 3'd4
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic [GlyphW-1:0] glyph;
  } op_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  function automatic logic [GlyphW-1:0] font_row(input logic [5:0] idx);
    logic [GlyphW-1:0] g;
    unique case (idx)
      6'd0:  g = 40'h0000000000;
      6'd1:  g = 40'h00005f0000;
      6'd2:  g = 40'h0007000700;
      6'd3:  g = 40'h24ff24ff24;
      6'd4:  g = 40'h6291ff8a44;
      6'd5:  g = 40'he2a4182547;
      6'd6:  g = 40'hd062958976;
      6'd7:  g = 40'h0000070000;
      6'd8:  g = 40'h0081423c00;
      6'd9:  g = 40'h003c428100;
      6'd10: g = 40'h22147f1422;
      6'd11: g = 40'h08083e0808;
      6'd12: g = 40'h000060a000;
      6'd13: g = 40'h0808080808;
      6'd14: g = 40'h0000606000;
      6'd15: g = 40'h00030c30c0;
      6'd16: g = 40'h7e8599a17e;
      6'd17: g = 40'h8080ff8284;
      6'd18: g = 40'h868991a1c1;
      6'd19: g = 40'h7689898989;
      6'd20: g = 40'h10ff121418;
      6'd21: g = 40'h718989898f;
      6'd22: g = 40'h728989897e;
      6'd23: g = 40'h0719618101;
      6'd24: g = 40'h6295899562;
      6'd25: g = 40'h7e9191914e;
      6'd26: g = 40'h0000363600;
      6'd27: g = 40'h000076b600;
      6'd28: g = 40'h8041221408;
      6'd29: g = 40'h2424242424;
      6'd30: g = 40'h0814224180;
      6'd31: g = 40'h0609b10102;
      6'd32: g = 40'h1ea5bd817e;
      6'd33: g = 40'hfe111111fe;
      6'd34: g = 40'h76898989ff;
      6'd35: g = 40'h818181817e;
      6'd36: g = 40'h7e818181ff;
      6'd37: g = 40'h89898989ff;
      6'd38: g = 40'h09090909ff;
      6'd39: g = 40'hf15191817e;
      6'd40: g = 40'hff080808ff;
      6'd41: g = 40'h0081ff8100;
      6'd42: g = 40'h7f80808040;
      6'd43: g = 40'hc1221408ff;
      6'd44: g = 40'h80808080ff;
      6'd45: g = 40'hff020402ff;
      6'd46: g = 40'hff601806ff;
      6'd47: g = 40'h7e8181817e;
      6'd48: g = 40'h0e111111ff;
      6'd49: g = 40'hfec1a1817e;
      6'd50: g = 40'hee111111ff;
      6'd51: g = 40'h7189898986;
      6'd52: g = 40'h0101ff0101;
      6'd53: g = 40'h7f8080807f;
      6'd54: g = 40'h1f6080601f;
      6'd55: g = 40'hff402040ff;
      6'd56: g = 40'hc7281028c7;
      6'd57: g = 40'h0708f00807;
      6'd58: g = 40'h838599a1c1;
      6'd59: g = 40'h008181ff00;
      6'd60: g = 40'h00c0300c03;
      6'd61: g = 40'h00ff818100;
      6'd62: g = 40'h0609b10102;
      6'd63: g = 40'h8080808080;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

  function automatic logic [GlyphW-1:0] glyph_of(input logic [CharW-1:0] code);
    logic [CharW-1:0]  c;
    logic [GlyphW-1:0] g;
    c = code;
    if (c >= ChLowA && c <= ChLowZ) begin
      c = c - CaseGap;
    end
    if (c == ChBar) begin
      g = GlyphBar;
    end else if (c >= ChSpace && c < ChGrave) begin
      g = font_row(6'(c - ChSpace));
    end else begin
      g = font_row(UnknownIdx);
    end
    return g;
  endfunction

endpackage

FILE: sv/ttc_if.sv
// ----------------------------------------------------------------------------
// ttc interfaces
// valid/ready channels for characters, drawing commands and register writes
// ----------------------------------------------------------------------------
interface ttc_char_if;
  logic                       valid;
  logic                       ready;
  logic [ttc_pkg::CharW-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ttc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ttc_pkg::CmdW-1:0]     command;
  logic [ttc_pkg::CellColW-1:0] cell_col;
  logic [ttc_pkg::CellRowW-1:0] cell_row;
  logic [ttc_pkg::PixW-1:0]     pixel_x;
  logic [ttc_pkg::PixW-1:0]     pixel_y;
  logic [ttc_pkg::GlyphW-1:0]   glyph_bits;
  logic                         last;

  modport source (output valid, output command, output cell_col, output cell_row,
                  output pixel_x, output pixel_y, output glyph_bits, output last,
                  input ready);
  modport sink   (input valid, input command, input cell_col, input cell_row,
                  input pixel_x, input pixel_y, input glyph_bits, input last,
                  output ready);
endinterface

interface ttc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ttc_pkg::CfgIdxW-1:0]   index;
  logic [ttc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/ttc_front.sv
// ----------------------------------------------------------------------------
// ttc_front
// accepts character items, classifies them and looks up the glyph
// ----------------------------------------------------------------------------
module ttc_front (
  ttc_char_if.sink        char_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output ttc_pkg::op_t    q_op_o
);

  logic keep;

  always_comb begin
    keep          = 1'b1;
    q_op_o.glyph  = ttc_pkg::GlyphSpace;
    q_op_o.kind   = ttc_pkg::OP_DRAW;
    priority if (char_i.char_code == ttc_pkg::ChCr) begin
      q_op_o.kind = ttc_pkg::OP_CR;
    end else if (char_i.char_code == ttc_pkg::ChLf) begin
      q_op_o.kind = ttc_pkg::OP_LF;
    end else if (char_i.char_code == ttc_pkg::ChTab) begin
      q_op_o.kind = ttc_pkg::OP_TAB;
    end else if (char_i.char_code == ttc_pkg::ChBs) begin
      q_op_o.kind = ttc_pkg::OP_BS;
    end else if (char_i.char_code >= ttc_pkg::ChSpace &&
                 char_i.char_code <  ttc_pkg::ChDel) begin
      q_op_o.glyph = ttc_pkg::glyph_of(char_i.char_code);
    end else begin
      keep = 1'b0;
    end
  end

  assign char_i.ready = !q_full_i;
  assign q_push_o     = char_i.valid && !q_full_i && keep;

endmodule

FILE: sv/ttc_fifo.sv
// ----------------------------------------------------------------------------
// ttc_fifo
// short queue of classified operations between front and back
// ----------------------------------------------------------------------------
module ttc_fifo #(
  parameter int unsigned Depth = ttc_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttc_pkg::op_t  push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ttc_pkg::op_t  pop_op_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ttc_pkg::op_t     mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: sv/ttc_back.sv
// ----------------------------------------------------------------------------
// ttc_back
// cursor sequencer: turns operations into drawing commands while the sink is not stalling, one per cycle
// ----------------------------------------------------------------------------
module ttc_back #(
  parameter int unsigned MaxCols = ttc_pkg::MaxColsDef,
  parameter int unsigned MaxRows = ttc_pkg::MaxRowsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ttc_pkg::cfg_wr_t cfg_wr_i,
  input  logic             op_valid_i,
  input  ttc_pkg::op_t     op_i,
  output logic             op_pop_o,
  ttc_cmd_if.source        cmd_o
);

  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned ColCntW = ColW + 1;
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned RowCntW = RowW + 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_TAB    = 3'b010,
    ST_SCROLL = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [7:0]  columns_q;
  logic [6:0]  rows_q;
  logic [9:0]  origin_x_q, origin_y_q;

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [8:0]         cols_ext;
  logic [7:0]         rows_ext;
  logic [ColCntW-1:0] eff_cols;
  logic [RowCntW-1:0] eff_rows;
  logic [ColCntW-1:0] col1;
  logic [RowCntW-1:0] row1;
  logic               wrap, bottom;

  logic                       advance;
  logic                       do_draw, draw_tab;
  logic [ttc_pkg::GlyphW-1:0] draw_glyph;

  logic                       emit;
  ttc_pkg::cmd_e              em_cmd;
  logic [ColW-1:0]            em_col;
  logic [RowW-1:0]            em_row;
  logic [ttc_pkg::GlyphW-1:0] em_glyph;
  logic                       em_last;
  logic [ColW+2:0]            col6;
  logic [RowW+3:0]            row10;

  logic                         out_valid_q;
  logic [ttc_pkg::CmdW-1:0]     out_cmd_q;
  logic [ttc_pkg::CellColW-1:0] out_col_q;
  logic [ttc_pkg::CellRowW-1:0] out_row_q;
  logic [ttc_pkg::PixW-1:0]     out_px_q, out_py_q;
  logic [ttc_pkg::GlyphW-1:0]   out_glyph_q;
  logic                         out_last_q;

  // clamp the line and screen sizes
  assign cols_ext = {1'b0, columns_q};
  assign rows_ext = {1'b0, rows_q};
  assign eff_cols = (columns_q == '0) ? ColCntW'(1) :
                    (cols_ext > 9'(MaxCols)) ? ColCntW'(MaxCols) : ColCntW'(cols_ext);
  assign eff_rows = (rows_q == '0) ? RowCntW'(1) :
                    (rows_ext > 8'(MaxRows)) ? RowCntW'(MaxRows) : RowCntW'(rows_ext);

  assign col1   = {1'b0, col_q} + ColCntW'(1);
  assign row1   = {1'b0, row_q} + RowCntW'(1);
  assign wrap   = (col1 >= eff_cols);
  assign bottom = (row1 >= eff_rows);

  assign advance = !out_valid_q || cmd_o.ready;

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    op_pop_o   = 1'b0;
    do_draw    = 1'b0;
    draw_tab   = 1'b0;
    draw_glyph = ttc_pkg::GlyphSpace;
    emit       = 1'b0;
    em_cmd     = ttc_pkg::CMD_DRAW;
    em_col     = col_q;
    em_row     = row_q;
    em_glyph   = '0;
    em_last    = 1'b0;

    if (advance) begin
      unique case (state_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            op_pop_o = 1'b1;
            unique case (op_i.kind)
              ttc_pkg::OP_CR: begin
                col_d = '0;
              end
              ttc_pkg::OP_LF: begin
                col_d = '0;
                if (bottom) begin
                  emit    = 1'b1;
                  em_cmd  = ttc_pkg::CMD_SCROLL;
                  em_last = 1'b1;
                end else begin
                  row_d = row1[RowW-1:0];
                end
              end
              ttc_pkg::OP_BS: begin
                if (col_q != '0) begin
                  col_d   = col_q - ColW'(1);
                  emit    = 1'b1;
                  em_cmd  = ttc_pkg::CMD_CLEAR;
                  em_col  = col_q - ColW'(1);
                  em_last = 1'b1;
                end
              end
              ttc_pkg::OP_TAB: begin
                do_draw  = 1'b1;
                draw_tab = 1'b1;
              end
              ttc_pkg::OP_DRAW: begin
                do_draw    = 1'b1;
                draw_glyph = op_i.glyph;
              end
              default: ;
            endcase
          end
        end
        ST_TAB: begin
          do_draw  = 1'b1;
          draw_tab = 1'b1;
        end
        ST_SCROLL: begin
          emit    = 1'b1;
          em_cmd  = ttc_pkg::CMD_SCROLL;
          em_last = 1'b1;
          state_d = ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase

      if (do_draw) begin
        emit     = 1'b1;
        em_cmd   = ttc_pkg::CMD_DRAW;
        em_glyph = draw_glyph;
        if (wrap) begin
          col_d = '0;
          if (!bottom) begin
            row_d = row1[RowW-1:0];
          end
        end else begin
          col_d = col1[ColW-1:0];
        end
        if (wrap && bottom) begin
          state_d = ST_SCROLL;
        end else if (draw_tab && !wrap && col1[2:0] != 3'd0) begin
          state_d = ST_TAB;
        end else begin
          state_d = ST_IDLE;
          em_last = 1'b1;
        end
      end
    end
  end

  assign col6  = ({3'b000, em_col} << 2) + ({3'b000, em_col} << 1);
  assign row10 = ({4'b0000, em_row} << 3) + ({4'b0000, em_row} << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      columns_q   <= ttc_pkg::ColumnsRst;
      rows_q      <= ttc_pkg::RowsRst;
      origin_x_q  <= ttc_pkg::OriginXRst;
      origin_y_q  <= ttc_pkg::OriginYRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_i.valid) begin
        col_q <= '0;
        row_q <= '0;
        unique case (cfg_wr_i.index)
          ttc_pkg::CfgColumns: columns_q  <= cfg_wr_i.data[7:0];
          ttc_pkg::CfgRows:    rows_q     <= cfg_wr_i.data[6:0];
          ttc_pkg::CfgOriginX: origin_x_q <= cfg_wr_i.data;
          ttc_pkg::CfgOriginY: origin_y_q <= cfg_wr_i.data;
          default: ;
        endcase
      end else begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (advance) begin
        out_valid_q <= emit;
      end
    end
  end

  // payload, zeroed position for scroll
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_cmd_q   <= em_cmd;
      out_glyph_q <= em_glyph;
      out_last_q  <= em_last;
      if (em_cmd == ttc_pkg::CMD_SCROLL) begin
        out_col_q <= '0;
        out_row_q <= '0;
        out_px_q  <= '0;
        out_py_q  <= '0;
      end else begin
        out_col_q <= ttc_pkg::CellColW'(em_col);
        out_row_q <= ttc_pkg::CellRowW'(em_row);
        out_px_q  <= origin_x_q + ttc_pkg::PixW'(col6);
        out_py_q  <= origin_y_q + ttc_pkg::PixW'(row10);
      end
    end
  end

  assign cmd_o.valid      = out_valid_q;
  assign cmd_o.command    = out_cmd_q;
  assign cmd_o.cell_col   = out_col_q;
  assign cmd_o.cell_row   = out_row_q;
  assign cmd_o.pixel_x    = out_px_q;
  assign cmd_o.pixel_y    = out_py_q;
  assign cmd_o.glyph_bits = out_glyph_q;
  assign cmd_o.last       = out_last_q;

endmodule

FILE: sv/text_console_cursor_renderer.sv
// an accepted item is registered in the operation queue, and its commands in the
//   back sequencer's output register, one per cycle while the sink is ready;
//   a character gives 0 to 9 commands (a tab up to 9)
// a 2-entry operation queue lets the front accept while the back is busy
// reset: cursor at column 0 row 0, columns 48, rows 21, origin 16,12, queue empty
// ----------------------------------------------------------------------------
// text_console_cursor_renderer
// character stream to cell drawing commands with a 5x8 font and text cursor
// ----------------------------------------------------------------------------
module text_console_cursor_renderer #(
  parameter int unsigned MaxCols    = ttc_pkg::MaxColsDef,
  parameter int unsigned MaxRows    = ttc_pkg::MaxRowsDef,
  parameter int unsigned QueueDepth = ttc_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttc_char_if.sink   char_i,
  ttc_cfg_if.sink    cfg_i,
  ttc_cmd_if.source  cmd_o
);

  logic             q_full, q_push, q_pop, q_valid;
  ttc_pkg::op_t     q_push_op, q_pop_op;
  ttc_pkg::cfg_wr_t cfg_wr;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  ttc_front u_front (
    .char_i   (char_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_op_o   (q_push_op)
  );

  ttc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (q_pop_op)
  );

  ttc_back #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .op_valid_i (q_valid),
    .op_i       (q_pop_op),
    .op_pop_o   (q_pop),
    .cmd_o      (cmd_o)
  );

endmodule

FILE: tb/sv/text_console_cursor_renderer_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_renderer_tb
// Sends character items into the console renderer and checks every drawing
// command against a cycle-free model of the cursor and font kept here. A short
// table of directed characters runs first, then random character streams
// under a range of screen geometries and origins, with random idling on both
// channels, one long stall of the command sink and one full drain mid-stream.
// ----------------------------------------------------------------------------
module text_console_cursor_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ItemsPerSet = 26;
  localparam int unsigned NumSettings = 10;
  localparam int unsigned MaxPerChar  = 9;

  typedef struct packed {
    cmd_e              command;
    logic [6:0]        col;
    logic [5:0]        row;
    logic [9:0]        px;
    logic [9:0]        py;
    logic [GlyphW-1:0] glyph;
    logic              last;
  } draw_cmd_t;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             typed;
    draw_cmd_t        want;
  } char_row_t;

  localparam draw_cmd_t NoCmd = '0;

  logic clk;
  logic rst_n;

  ttc_char_if char_ch ();
  ttc_cfg_if  cfg_ch ();
  ttc_cmd_if  cmd_ch ();

  text_console_cursor_renderer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_ch),
    .cfg_i  (cfg_ch),
    .cmd_o  (cmd_ch)
  );

  // screen model
  logic [7:0]  reg_cols;
  logic [6:0]  reg_rows;
  logic [9:0]  reg_ox;
  logic [9:0]  reg_oy;
  int unsigned cur_col;
  int unsigned cur_row;

  draw_cmd_t   new_cmds[$];
  draw_cmd_t   due_cmds[$];

  int unsigned mismatches;
  int unsigned cmds_checked;
  int unsigned scrolls_checked;
  int unsigned chars_sent;
  int unsigned settings_done;
  int unsigned cycles;

  logic        tx_burst;
  logic        rx_burst;
  logic        rx_hold_req;

  // reset-time cursor at the top left; typed rows read straight off the font
  char_row_t dir_table [22] = '{
    '{8'h41, 1'b1, '{CMD_DRAW,  7'd0, 6'd0, 10'd16, 10'd12, 40'hfe111111fe, 1'b1}},
    '{8'h61, 1'b1, '{CMD_DRAW,  7'd1, 6'd0, 10'd22, 10'd12, 40'hfe111111fe, 1'b1}},
    '{ChBs,  1'b1, '{CMD_CLEAR, 7'd1, 6'd0, 10'd22, 10'd12, 40'h0000000000, 1'b1}},
    '{ChBs,  1'b1, '{CMD_CLEAR, 7'd0, 6'd0, 10'd16, 10'd12, 40'h0000000000, 1'b1}},
    '{ChBs,  1'b0, NoCmd},
    '{8'h7c, 1'b1, '{CMD_DRAW,  7'd0, 6'd0, 10'd16, 10'd12, 40'h0000ff0000, 1'b1}},
    '{8'h7e, 1'b1, '{CMD_DRAW,  7'd1, 6'd0, 10'd22, 10'd12, 40'h0609b10102, 1'b1}},
    '{8'h7f, 1'b0, NoCmd},
    '{8'hff, 1'b0, NoCmd},
    '{8'h00, 1'b0, NoCmd},
    '{8'h1b, 1'b0, NoCmd},
    '{8'h20, 1'b1, '{CMD_DRAW,  7'd2, 6'd0, 10'd28, 10'd12, 40'h0000000000, 1'b1}},
    '{8'h5f, 1'b1, '{CMD_DRAW,  7'd3, 6'd0, 10'd34, 10'd12, 40'h8080808080, 1'b1}},
    '{8'h60, 1'b1, '{CMD_DRAW,  7'd4, 6'd0, 10'd40, 10'd12, 40'h0609b10102, 1'b1}},
    '{8'h7b, 1'b0, NoCmd},
    '{8'h7a, 1'b0, NoCmd},
    '{ChTab, 1'b0, NoCmd},
    '{ChTab, 1'b0, NoCmd},
    '{ChCr,  1'b0, NoCmd},
    '{ChLf,  1'b0, NoCmd},
    '{8'h30, 1'b0, NoCmd},
    '{8'h39, 1'b0, NoCmd}
  };

  // columns, rows, origin x, origin y as raw write data
  logic [9:0] fixed_settings [8][4] = '{
    '{10'h300, 10'h380, 10'd1023, 10'd1023},
    '{10'd1,   10'd1,   10'd0,    10'd0},
    '{10'h3ff, 10'h3ff, 10'd1023, 10'd1023},
    '{10'd128, 10'd64,  10'd1000, 10'd500},
    '{10'd5,   10'd3,   10'd1020, 10'd1010},
    '{10'd8,   10'd2,   10'd0,    10'd1023},
    '{10'd13,  10'd4,   10'd511,  10'd512},
    '{10'd129, 10'd65,  10'd700,  10'd3}
  };

  function automatic logic [GlyphW-1:0] cols5(input logic [7:0] c0, c1, c2, c3, c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  function automatic logic [GlyphW-1:0] font_glyph(input logic [5:0] idx);
    logic [GlyphW-1:0] g;
    case (idx)
      6'd0:  g = cols5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      6'd1:  g = cols5(8'h00, 8'h00, 8'h5f, 8'h00, 8'h00);
      6'd2:  g = cols5(8'h00, 8'h07, 8'h00, 8'h07, 8'h00);
      6'd3:  g = cols5(8'h24, 8'hff, 8'h24, 8'hff, 8'h24);
      6'd4:  g = cols5(8'h44, 8'h8a, 8'hff, 8'h91, 8'h62);
      6'd5:  g = cols5(8'h47, 8'h25, 8'h18, 8'ha4, 8'he2);
      6'd6:  g = cols5(8'h76, 8'h89, 8'h95, 8'h62, 8'hd0);
      6'd7:  g = cols5(8'h00, 8'h00, 8'h07, 8'h00, 8'h00);
      6'd8:  g = cols5(8'h00, 8'h3c, 8'h42, 8'h81, 8'h00);
      6'd9:  g = cols5(8'h00, 8'h81, 8'h42, 8'h3c, 8'h00);
      6'd10: g = cols5(8'h22, 8'h14, 8'h7f, 8'h14, 8'h22);
      6'd11: g = cols5(8'h08, 8'h08, 8'h3e, 8'h08, 8'h08);
      6'd12: g = cols5(8'h00, 8'ha0, 8'h60, 8'h00, 8'h00);
      6'd13: g = cols5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      6'd14: g = cols5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      6'd15: g = cols5(8'hc0, 8'h30, 8'h0c, 8'h03, 8'h00);
      6'd16: g = cols5(8'h7e, 8'ha1, 8'h99, 8'h85, 8'h7e);
      6'd17: g = cols5(8'h84, 8'h82, 8'hff, 8'h80, 8'h80);
      6'd18: g = cols5(8'hc1, 8'ha1, 8'h91, 8'h89, 8'h86);
      6'd19: g = cols5(8'h89, 8'h89, 8'h89, 8'h89, 8'h76);
      6'd20: g = cols5(8'h18, 8'h14, 8'h12, 8'hff, 8'h10);
      6'd21: g = cols5(8'h8f, 8'h89, 8'h89, 8'h89, 8'h71);
      6'd22: g = cols5(8'h7e, 8'h89, 8'h89, 8'h89, 8'h72);
      6'd23: g = cols5(8'h01, 8'h81, 8'h61, 8'h19, 8'h07);
      6'd24: g = cols5(8'h62, 8'h95, 8'h89, 8'h95, 8'h62);
      6'd25: g = cols5(8'h4e, 8'h91, 8'h91, 8'h91, 8'h7e);
      6'd26: g = cols5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      6'd27: g = cols5(8'h00, 8'hb6, 8'h76, 8'h00, 8'h00);
      6'd28: g = cols5(8'h08, 8'h14, 8'h22, 8'h41, 8'h80);
      6'd29: g = cols5(8'h24, 8'h24, 8'h24, 8'h24, 8'h24);
      6'd30: g = cols5(8'h80, 8'h41, 8'h22, 8'h14, 8'h08);
      6'd31: g = cols5(8'h02, 8'h01, 8'hb1, 8'h09, 8'h06);
      6'd32: g = cols5(8'h7e, 8'h81, 8'hbd, 8'ha5, 8'h1e);
      6'd33: g = cols5(8'hfe, 8'h11, 8'h11, 8'h11, 8'hfe);
      6'd34: g = cols5(8'hff, 8'h89, 8'h89, 8'h89, 8'h76);
      6'd35: g = cols5(8'h7e, 8'h81, 8'h81, 8'h81, 8'h81);
      6'd36: g = cols5(8'hff, 8'h81, 8'h81, 8'h81, 8'h7e);
      6'd37: g = cols5(8'hff, 8'h89, 8'h89, 8'h89, 8'h89);
      6'd38: g = cols5(8'hff, 8'h09, 8'h09, 8'h09, 8'h09);
      6'd39: g = cols5(8'h7e, 8'h81, 8'h91, 8'h51, 8'hf1);
      6'd40: g = cols5(8'hff, 8'h08, 8'h08, 8'h08, 8'hff);
      6'd41: g = cols5(8'h00, 8'h81, 8'hff, 8'h81, 8'h00);
      6'd42: g = cols5(8'h40, 8'h80, 8'h80, 8'h80, 8'h7f);
      6'd43: g = cols5(8'hff, 8'h08, 8'h14, 8'h22, 8'hc1);
      6'd44: g = cols5(8'hff, 8'h80, 8'h80, 8'h80, 8'h80);
      6'd45: g = cols5(8'hff, 8'h02, 8'h04, 8'h02, 8'hff);
      6'd46: g = cols5(8'hff, 8'h06, 8'h18, 8'h60, 8'hff);
      6'd47: g = cols5(8'h7e, 8'h81, 8'h81, 8'h81, 8'h7e);
      6'd48: g = cols5(8'hff, 8'h11, 8'h11, 8'h11, 8'h0e);
      6'd49: g = cols5(8'h7e, 8'h81, 8'ha1, 8'hc1, 8'hfe);
      6'd50: g = cols5(8'hff, 8'h11, 8'h11, 8'h11, 8'hee);
      6'd51: g = cols5(8'h86, 8'h89, 8'h89, 8'h89, 8'h71);
      6'd52: g = cols5(8'h01, 8'h01, 8'hff, 8'h01, 8'h01);
      6'd53: g = cols5(8'h7f, 8'h80, 8'h80, 8'h80, 8'h7f);
      6'd54: g = cols5(8'h1f, 8'h60, 8'h80, 8'h60, 8'h1f);
      6'd55: g = cols5(8'hff, 8'h40, 8'h20, 8'h40, 8'hff);
      6'd56: g = cols5(8'hc7, 8'h28, 8'h10, 8'h28, 8'hc7);
      6'd57: g = cols5(8'h07, 8'h08, 8'hf0, 8'h08, 8'h07);
      6'd58: g = cols5(8'hc1, 8'ha1, 8'h99, 8'h85, 8'h83);
      6'd59: g = cols5(8'h00, 8'hff, 8'h81, 8'h81, 8'h00);
      6'd60: g = cols5(8'h03, 8'h0c, 8'h30, 8'hc0, 8'h00);
      6'd61: g = cols5(8'h00, 8'h81, 8'h81, 8'hff, 8'h00);
      6'd62: g = cols5(8'h02, 8'h01, 8'hb1, 8'h09, 8'h06);
      default: g = cols5(8'h80, 8'h80, 8'h80, 8'h80, 8'h80);
    endcase
    return g;
  endfunction

  function automatic logic [GlyphW-1:0] glyph_for(input logic [CharW-1:0] code);
    logic [CharW-1:0] c;
    c = code;
    if (c >= ChLowA && c <= ChLowZ) c = c - CaseGap;
    if (c == ChBar) return cols5(8'h00, 8'h00, 8'hff, 8'h00, 8'h00);
    if (c >= ChSpace && c < ChGrave) return font_glyph(6'(c - ChSpace));
    return font_glyph(6'(8'h3f - ChSpace));
  endfunction

  function automatic int unsigned line_len();
    if (reg_cols == 8'd0) return 1;
    if (reg_cols > MaxColsDef) return MaxColsDef;
    return reg_cols;
  endfunction

  function automatic int unsigned screen_rows();
    if (reg_rows == 7'd0) return 1;
    if (reg_rows > MaxRowsDef) return MaxRowsDef;
    return reg_rows;
  endfunction

  task automatic push_cmd(input cmd_e op, input logic [GlyphW-1:0] g);
    draw_cmd_t d;
    d = '0;
    if (new_cmds.size() >= MaxPerChar) return;
    d.command = op;
    if (op != CMD_SCROLL) begin
      d.col = 7'(cur_col);
      d.row = 6'(cur_row);
      d.px  = 10'(reg_ox + cur_col * 6);
      d.py  = 10'(reg_oy + cur_row * 10);
      d.glyph = g;
    end
    new_cmds.push_back(d);
  endtask

  task automatic advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= screen_rows()) begin
      push_cmd(CMD_SCROLL, '0);
      cur_row = screen_rows() - 1;
    end
  endtask

  task automatic put_glyph(input logic [CharW-1:0] code);
    push_cmd(CMD_DRAW, glyph_for(code));
    cur_col++;
    if (cur_col >= line_len()) advance_line();
  endtask

  task automatic render_char(input logic [CharW-1:0] code);
    int unsigned guard;
    new_cmds.delete();
    if (cur_col >= line_len()) cur_col = 0;
    if (cur_row >= screen_rows()) cur_row = 0;
    if (code == ChCr) begin
      cur_col = 0;
    end else if (code == ChLf) begin
      advance_line();
    end else if (code == ChTab) begin
      guard = 0;
      do begin
        put_glyph(ChSpace);
        guard++;
      end while ((cur_col % 8) != 0 && guard < 8);
    end else if (code == ChBs) begin
      if (cur_col > 0) begin
        cur_col--;
        push_cmd(CMD_CLEAR, '0);
      end
    end else if (code >= ChSpace && code < ChDel) begin
      put_glyph(code);
    end
    if (new_cmds.size() > 0) new_cmds[new_cmds.size() - 1].last = 1'b1;
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CfgColumns: reg_cols = data[7:0];
      CfgRows:    reg_rows = data[6:0];
      CfgOriginX: reg_ox   = data;
      CfgOriginY: reg_oy   = data;
      default: ;
    endcase
    cur_col = 0;
    cur_row = 0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at command %0d: %s", cmds_checked, msg);
    mismatches++;
  endtask

  task automatic check_field(input string fname, input logic [GlyphW-1:0] got,
                             input logic [GlyphW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", fname, got, want));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    set_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [9:0] c, r, x, y);
    write_reg(CfgColumns, c);
    write_reg(CfgRows, r);
    write_reg(CfgOriginX, x);
    write_reg(CfgOriginY, y);
    cfg_ch.valid <= 1'b0;
    settings_done++;
  endtask

  task automatic send_char(input logic [CharW-1:0] code);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= code;
    do @(posedge clk); while (!char_ch.ready);
    chars_sent++;
  endtask

  task automatic feed_char(input logic [CharW-1:0] code, input logic typed,
                           input draw_cmd_t want);
    send_char(code);
    render_char(code);
    if (typed) begin
      due_cmds.push_back(want);
    end else begin
      foreach (new_cmds[k]) due_cmds.push_back(new_cmds[k]);
    end
  endtask

  task automatic wait_idle();
    while (due_cmds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [CharW-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(32, 126));
    if (r < 60) return ChTab;
    if (r < 68) return ChLf;
    if (r < 73) return ChCr;
    if (r < 83) return ChBs;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic handled(input logic [CharW-1:0] code);
    return code == ChCr || code == ChLf || code == ChTab || code == ChBs ||
           (code >= ChSpace && code < ChDel);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d commands still due", cycles, due_cmds.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    draw_cmd_t want;
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      if (due_cmds.size() == 0) begin
        report_mismatch("command arrived with none due");
      end else begin
        want = due_cmds.pop_front();
        check_field("command", cmd_ch.command, want.command);
        check_field("cell_col", cmd_ch.cell_col, want.col);
        check_field("cell_row", cmd_ch.cell_row, want.row);
        check_field("pixel_x", cmd_ch.pixel_x, want.px);
        check_field("pixel_y", cmd_ch.pixel_y, want.py);
        check_field("glyph_bits", cmd_ch.glyph_bits, want.glyph);
        check_field("last", cmd_ch.last, want.last);
        if (want.command == CMD_SCROLL) scrolls_checked++;
      end
      cmds_checked++;
    end
  end

  initial begin : cmd_sink
    int unsigned gap;
    logic held;
    held = 1'b0;
    cmd_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req && !held) begin
        held = 1'b1;
        gap = HoldCycles;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 7);
      end
      if (gap != 0) begin
        cmd_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cmd_ch.ready <= 1'b1;
      do @(posedge clk); while (!cmd_ch.valid);
    end
  end

  initial begin : stimulus
    int unsigned counted;
    logic [CharW-1:0] c;
    logic paused;

    chars_sent = 0;
    settings_done = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    rx_hold_req = 1'b0;
    paused = 1'b0;
    reg_cols = ColumnsRst;
    reg_rows = RowsRst;
    reg_ox = OriginXRst;
    reg_oy = OriginYRst;
    cur_col = 0;
    cur_row = 0;

    rst_n <= 1'b0;
    char_ch.valid <= 1'b0;
    char_ch.char_code <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CfgColumns;
    cfg_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) feed_char(dir_table[i].code, dir_table[i].typed, dir_table[i].want);
    char_ch.valid <= 1'b0;

    for (int unsigned p = 0; p < NumSettings; p++) begin
      wait_idle();
      if (p < 8) begin
        apply_setting(fixed_settings[p][0], fixed_settings[p][1],
                      fixed_settings[p][2], fixed_settings[p][3]);
      end else begin
        apply_setting(10'(($urandom_range(0, 3) << 8) | $urandom_range(1, 20)),
                      10'(($urandom_range(0, 7) << 7) | $urandom_range(1, 6)),
                      10'($urandom), 10'($urandom));
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      // long sink stall while characters keep coming, so the input backs up
      if (p == 2) begin
        tx_burst = 1'b1;
        rx_hold_req = 1'b1;
      end
      counted = 0;
      while (counted < ItemsPerSet) begin
        c = pick_char();
        feed_char(c, 1'b0, NoCmd);
        if (handled(c)) counted++;
        if (p == 4 && counted == 15 && !paused) begin
          paused = 1'b1;
          char_ch.valid <= 1'b0;
          wait_idle();
        end
      end
      char_ch.valid <= 1'b0;
    end

    wait_idle();
    $display("sent %0d characters under %0d register settings", chars_sent, settings_done);
    $display("checked %0d commands, %0d of them scrolls, %0d mismatches",
             cmds_checked, scrolls_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
